// ===== src/nlr_pkg.sv =====
// Shared types, codes and transition table of the numeric literal recognizer.
`timescale 1ns / 1ps
`default_nettype none
package nlr_pkg;

	// character classes
	localparam logic [2:0] CLS_OTHER   = 3'd0;
	localparam logic [2:0] CLS_SIGN    = 3'd1;
	localparam logic [2:0] CLS_GROUP   = 3'd2;
	localparam logic [2:0] CLS_DIGIT   = 3'd3;
	localparam logic [2:0] CLS_DECIMAL = 3'd4;
	localparam logic [2:0] CLS_EXP     = 3'd5;

	// scan phases
	localparam logic [3:0] PH_INIT = 4'd0;
	localparam logic [3:0] PH_LAST = 4'd8;
	localparam logic [3:0] PH_DONE = 4'd9;

	// result status codes
	localparam logic [1:0] ST_SCAN   = 2'd0;
	localparam logic [1:0] ST_ACCEPT = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_PLUS    = 3'd0;
	localparam logic [2:0] REG_MINUS   = 3'd1;
	localparam logic [2:0] REG_ZERO    = 3'd2;
	localparam logic [2:0] REG_DECIMAL = 3'd3;
	localparam logic [2:0] REG_GROUP   = 3'd4;
	localparam logic [2:0] REG_EXP_LO  = 3'd5;
	localparam logic [2:0] REG_EXP_UP  = 3'd6;

	localparam logic [15:0] NOT_A_CHAR = 16'hFFFF;

	// C-locale characters
	localparam logic [6:0] ASC_PLUS  = 7'h2B;
	localparam logic [6:0] ASC_MINUS = 7'h2D;
	localparam logic [6:0] ASC_ZERO  = 7'h30;
	localparam logic [6:0] ASC_DOT   = 7'h2E;
	localparam logic [6:0] ASC_COMMA = 7'h2C;
	localparam logic [6:0] ASC_EXP_L = 7'h65;
	localparam logic [6:0] ASC_EXP_U = 7'h45;

	typedef logic [3:0] phase_t;

	// next phase, indexed by phase and class
	localparam phase_t NEXT_TBL [0:8][0:5] = '{
		'{4'd0, 4'd1, 4'd0, 4'd3, 4'd4, 4'd0},
		'{4'd0, 4'd0, 4'd0, 4'd3, 4'd4, 4'd0},
		'{4'd0, 4'd0, 4'd0, 4'd3, 4'd0, 4'd0},
		'{4'd9, 4'd9, 4'd2, 4'd3, 4'd4, 4'd6},
		'{4'd0, 4'd0, 4'd0, 4'd5, 4'd0, 4'd0},
		'{4'd9, 4'd9, 4'd0, 4'd5, 4'd0, 4'd6},
		'{4'd0, 4'd7, 4'd0, 4'd8, 4'd0, 4'd0},
		'{4'd0, 4'd0, 4'd0, 4'd8, 4'd0, 4'd0},
		'{4'd9, 4'd0, 4'd0, 4'd8, 4'd0, 4'd9}
	};

	typedef struct packed {
		logic [15:0] code_unit;
		logic        end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic       char_valid;
		logic [6:0] ascii_char;
		logic [7:0] scan_length;
	} out_item_t;

	typedef struct packed {
		logic [15:0] plus_char;
		logic [15:0] minus_char;
		logic [15:0] zero_char;
		logic [15:0] decimal_mark;
		logic [15:0] group_mark;
		logic [15:0] exp_lower_char;
		logic [15:0] exp_upper_char;
	} cfg_t;

	typedef struct packed {
		logic [2:0] cls;
		logic [6:0] ascii;
		logic       space;
		logic       term;
		logic       clash;
	} class_info_t;

endpackage
`default_nettype wire

// ===== src/nlr_classify.sv =====
// Character classifier: mark clash check, whitespace detect, class and ASCII form.
`timescale 1ns / 1ps
`default_nettype none
module nlr_classify
	import nlr_pkg::*;
(
	input  wire in_item_t    item,
	input  wire cfg_t        cfg,
	output class_info_t      info
);

	logic [15:0] c;
	logic [15:0] c_off;
	logic [15:0] dec_off;
	logic [15:0] grp_off;
	logic        c_digit;
	logic        dec_digit;
	logic        grp_digit;
	logic        dec_res;
	logic        grp_res;
	logic        term;
	logic [2:0]  cls;
	logic [6:0]  ascii;

	assign c       = item.code_unit;
	assign c_off   = c - cfg.zero_char;
	assign dec_off = cfg.decimal_mark - cfg.zero_char;
	assign grp_off = cfg.group_mark - cfg.zero_char;

	// digits: zero_char .. zero_char + 9
	assign c_digit   = (c >= cfg.zero_char) && (c_off <= 16'd9);
	assign dec_digit = (cfg.decimal_mark >= cfg.zero_char) && (dec_off <= 16'd9);
	assign grp_digit = (cfg.group_mark >= cfg.zero_char) && (grp_off <= 16'd9);

	// separators must not collide with signs, digits or exponent marks
	assign dec_res = (cfg.decimal_mark == cfg.plus_char) ||
		(cfg.decimal_mark == cfg.minus_char) || dec_digit ||
		(cfg.decimal_mark == cfg.exp_lower_char) ||
		(cfg.decimal_mark == cfg.exp_upper_char);
	assign grp_res = (cfg.group_mark == cfg.plus_char) ||
		(cfg.group_mark == cfg.minus_char) || grp_digit ||
		(cfg.group_mark == cfg.exp_lower_char) ||
		(cfg.group_mark == cfg.exp_upper_char);

	assign info.clash = (cfg.decimal_mark == cfg.group_mark) || dec_res || grp_res;
	assign term       = item.end_of_text || (c == NOT_A_CHAR);
	assign info.term  = term;

	// leading whitespace set
	assign info.space = (c == 16'h0020) || ((c >= 16'h0009) && (c <= 16'h000D)) ||
		(c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
		((c >= 16'h2000) && (c <= 16'h200A)) ||
		(c == 16'h2028) || (c == 16'h2029) || (c == 16'h202F) ||
		(c == 16'h205F) || (c == 16'h3000);

	// first match wins, terminator is always other
	always_comb begin
		cls   = CLS_OTHER;
		ascii = 7'd0;
		priority if (term) begin
			cls   = CLS_OTHER;
			ascii = 7'd0;
		end else if (c == cfg.plus_char) begin
			cls   = CLS_SIGN;
			ascii = ASC_PLUS;
		end else if (c == cfg.minus_char) begin
			cls   = CLS_SIGN;
			ascii = ASC_MINUS;
		end else if (c_digit) begin
			cls   = CLS_DIGIT;
			ascii = ASC_ZERO + {3'd0, c_off[3:0]};
		end else if (c == cfg.decimal_mark) begin
			cls   = CLS_DECIMAL;
			ascii = ASC_DOT;
		end else if (c == cfg.group_mark) begin
			cls   = CLS_GROUP;
			ascii = ASC_COMMA;
		end else if (c == cfg.exp_lower_char) begin
			cls   = CLS_EXP;
			ascii = ASC_EXP_L;
		end else if (c == cfg.exp_upper_char) begin
			cls   = CLS_EXP;
			ascii = ASC_EXP_U;
		end else begin
			cls   = CLS_OTHER;
			ascii = 7'd0;
		end
	end

	assign info.cls   = cls;
	assign info.ascii = ascii;

endmodule
`default_nettype wire

// ===== src/nlr_scan_core.sv =====
// Scan state registers and one table transition per character.
`timescale 1ns / 1ps
`default_nettype none
module nlr_scan_core
	import nlr_pkg::*;
#(
	parameter int MAX_LENGTH = 255
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              step,
	input  wire class_info_t info,
	output out_item_t        result
);

	localparam int CNT_W = $clog2(MAX_LENGTH + 1);

	phase_t           phase_q;
	logic             skip_q;
	logic [CNT_W-1:0] count_q;

	phase_t           phase_d;
	logic             skip_d;
	logic [CNT_W-1:0] count_d;
	phase_t           cur_phase;
	phase_t           nxt;
	logic [CNT_W+7:0] count_ext;

	// out-of-range phase restarts from the initial phase
	assign cur_phase = (phase_q > PH_LAST) ? PH_INIT : phase_q;
	assign nxt       = NEXT_TBL[cur_phase][info.cls];
	assign count_ext = {8'd0, count_q};

	always_comb begin
		phase_d = phase_q;
		skip_d  = skip_q;
		count_d = count_q;
		result  = '0;
		priority if (info.clash) begin
			result.status = ST_REJECT;
			phase_d = PH_INIT;
			skip_d  = 1'b1;
			count_d = '0;
		end else if (skip_q && !info.term && info.space) begin
			// drop leading whitespace, state holds
			result.status = ST_SCAN;
		end else if (nxt == PH_DONE) begin
			result.status      = ST_ACCEPT;
			result.scan_length = count_ext[7:0];
			phase_d = PH_INIT;
			skip_d  = 1'b1;
			count_d = '0;
		end else if ((nxt == PH_INIT) || (count_q >= CNT_W'(MAX_LENGTH))) begin
			result.status = ST_REJECT;
			phase_d = PH_INIT;
			skip_d  = 1'b1;
			count_d = '0;
		end else begin
			result.status     = ST_SCAN;
			result.char_valid = 1'b1;
			result.ascii_char = info.ascii;
			phase_d = nxt;
			skip_d  = 1'b0;
			count_d = count_q + 1'b1;
		end
	end

	// advance state on each processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_INIT;
			skip_q  <= 1'b1;
			count_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			skip_q  <= skip_d;
			count_q <= count_d;
		end
	end

endmodule
`default_nettype wire

// ===== src/numeric_literal_recognizer_unit.sv =====
// Top level: configuration registers, input register, scan core and result register.
// A result passes the input register and then the result register before it is valid.
// Throughput: one character per cycle while out_ready holds, set by the single table step per character.
// The input register refills in the cycle the result register is taken.
// Reset (arst_n low, asynchronous) empties both registers, rearms the scan and
// loads the default marks + - 0 . , e E.
`timescale 1ns / 1ps
`default_nettype none
module numeric_literal_recognizer_unit
	import nlr_pkg::*;
#(
	parameter int MAX_LENGTH = 255
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire            out_ready,
	output out_item_t      out_data,
	input  wire            cfg_we,
	input  wire [2:0]      cfg_index,
	input  wire [15:0]     cfg_wdata
);

	cfg_t        cfg_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        valid_s2;
	out_item_t   result_s2;
	logic        advance;
	class_info_t info;
	out_item_t   result;

	// configuration writes, indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.plus_char      <= 16'd43;
			cfg_q.minus_char     <= 16'd45;
			cfg_q.zero_char      <= 16'd48;
			cfg_q.decimal_mark   <= 16'd46;
			cfg_q.group_mark     <= 16'd44;
			cfg_q.exp_lower_char <= 16'd101;
			cfg_q.exp_upper_char <= 16'd69;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PLUS:    cfg_q.plus_char      <= cfg_wdata;
				REG_MINUS:   cfg_q.minus_char     <= cfg_wdata;
				REG_ZERO:    cfg_q.zero_char      <= cfg_wdata;
				REG_DECIMAL: cfg_q.decimal_mark   <= cfg_wdata;
				REG_GROUP:   cfg_q.group_mark     <= cfg_wdata;
				REG_EXP_LO:  cfg_q.exp_lower_char <= cfg_wdata;
				REG_EXP_UP:  cfg_q.exp_upper_char <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// process the held character when the result register has room
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	nlr_classify u_classify (
		.item (item_s1),
		.cfg  (cfg_q),
		.info (info)
	);

	nlr_scan_core #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.info   (info),
		.result (result)
	);

	// result register, holds until the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

endmodule
`default_nettype wire

// ===== src/nlr_checker.sv =====
// Port-level checker for the recognizer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nlr_checker
	import nlr_pkg::*;
(
	input wire            clk,
	input wire            arst_n,
	input wire            out_valid,
	input wire            out_ready,
	input wire out_item_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a joined character never ends the scan
	a_char_scan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.char_valid |-> out_data.status == ST_SCAN)
		else $error("joined character with final status");

	// length only on accept
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_ACCEPT |-> out_data.scan_length == 8'd0)
		else $error("length shown without accept");

	// ASCII form only for joined characters
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.char_valid |-> out_data.ascii_char == 7'd0)
		else $error("ASCII form without joined character");

endmodule

bind numeric_literal_recognizer_unit nlr_checker u_nlr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
`default_nettype wire
